// File: design/cow_layer_block_resolver_macros.svh
// assertion helpers shared by the resolver modules
`ifndef COW_LAYER_BLOCK_RESOLVER_MACROS_SVH
`define COW_LAYER_BLOCK_RESOLVER_MACROS_SVH

// property that must hold at every edge outside reset
`define CLBR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// trigger in one cycle implies a condition in the next
`define CLBR_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// File: design/clbr_pkg.sv
`timescale 1ns / 1ps
package clbr_pkg;

   localparam int BLK_SHIFT    = 12;
   localparam int BLOCK_BYTES  = 1 << BLK_SHIFT;
   localparam int BLK_W        = 16;
   localparam int NUM_BLOCKS   = 1 << BLK_W;
   localparam int OFF_W        = BLK_W + BLK_SHIFT;
   localparam int LEN_W        = 17;
   localparam int MAX_IO_BYTES = 65536;
   localparam int MAX_LAYERS   = 8;
   localparam int LAYER_W      = 3;
   localparam int LIU_W        = 4;
   localparam int LIU_RESET    = 2;
   localparam int STATUS_W     = 2;

   localparam logic [OFF_W:0]      DISK_BYTES = (OFF_W + 1)'(1) << OFF_W;
   localparam logic [MAX_LAYERS-1:0] BASE_BITS = MAX_LAYERS'(1);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NO_LAYER  = 2'd1,
      ST_BAD_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      EMIT_ERR,
      EMIT_WR,
      EMIT_SEG
   } emit_sel_type;

   typedef struct packed {
      logic         load_req;
      logic         clr_step;
      logic         rd_first;
      logic         rd_next;
      logic         wb;
      logic         emit;
      emit_sel_type emit_sel;
   } clbr_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic bad_range;
      logic is_write;
      logic at_final;
      logic out_free;
   } clbr_sts_type;

endpackage

// File: design/clbr_ram.sv
`timescale 1ns / 1ps
module clbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/clbr_ctrl.sv
`timescale 1ns / 1ps
`include "cow_layer_block_resolver_macros.svh"
module clbr_ctrl
   import clbr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output clbr_cmd_type cmd,
   input  clbr_sts_type sts
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_READ,
      S_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.emit_sel = EMIT_SEG;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load_req = 1'b1;
               state_in     = S_START;
            end
         end
         S_START: begin
            priority if (sts.bad_range) begin
               if (sts.out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = EMIT_ERR;
                  state_in     = S_IDLE;
               end
            end else if (sts.is_write) begin
               // the write word goes out first, then the bitmap sweep
               if (sts.out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = EMIT_WR;
                  cmd.rd_first = 1'b1;
                  state_in     = S_WRITE;
               end
            end else begin
               cmd.rd_first = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_SEG;
               if (sts.at_final) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         S_WRITE: begin
            // write back this block while fetching the next one
            cmd.wb = 1'b1;
            if (sts.at_final) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

   `CLBR_ASSERT_ALWAYS(a_emit_needs_room, !cmd.emit || sts.out_free, "emit into full output")
   `CLBR_ASSERT_ALWAYS(a_one_ram_writer, !(cmd.wb && cmd.clr_step), "two bitmap writers")
   `CLBR_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == S_START,
      "accepted word did not start")

endmodule

// File: design/clbr_dp.sv
`timescale 1ns / 1ps
`include "cow_layer_block_resolver_macros.svh"
module clbr_dp
   import clbr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  clbr_cmd_type         cmd,
   output clbr_sts_type         sts,
   input  logic                 csr_wr_en,
   input  logic [LIU_W-1:0]     csr_wr_data,
   input  logic                 req_operation,
   input  logic [OFF_W-1:0]     req_offset,
   input  logic [LEN_W-1:0]     req_length,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OFF_W-1:0]     rsp_seg_offset,
   output logic [LEN_W-1:0]     rsp_seg_length,
   output logic [LAYER_W-1:0]   rsp_src_layer,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_last
);

   logic [LIU_W-1:0]      liu_ff, liu_in;
   logic                  op_ff;
   logic [OFF_W-1:0]      off_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [OFF_W-1:0]      endm1_ff;
   logic                  bad_ff;
   logic [LAYER_W-1:0]    top_ff, top_in;
   logic [BLK_W-1:0]      blk_ff, blk_in;

   logic                  out_valid_ff, out_valid_in;
   logic [OFF_W-1:0]      out_off_ff, out_off_in;
   logic [LEN_W-1:0]      out_len_ff, out_len_in;
   logic [LAYER_W-1:0]    out_layer_ff, out_layer_in;
   status_type            out_status_ff, out_status_in;
   logic                  out_last_ff, out_last_in;

   logic [OFF_W:0]        req_sum;
   logic                  req_bad;
   logic [LIU_W-1:0]      layer_cnt;
   logic [BLK_W-1:0]      first_blk;
   logic [BLK_W-1:0]      final_blk;
   logic                  is_first;
   logic                  is_final;

   logic                  ram_wr_en;
   logic [BLK_W-1:0]      ram_wr_addr;
   logic [MAX_LAYERS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [BLK_W-1:0]      ram_rd_addr;
   logic [MAX_LAYERS-1:0] ram_rd_data;

   logic [MAX_LAYERS-1:0] layer_mask;
   logic [MAX_LAYERS-1:0] held_bits;
   logic [LAYER_W-1:0]    seg_layer;
   logic                  seg_found;
   logic [OFF_W-1:0]      seg_off;
   logic [LEN_W-1:0]      seg_len;

   // request checks and the active layer count
   always_comb begin
      req_sum = (OFF_W + 1)'(req_offset) + (OFF_W + 1)'(req_length);
      req_bad = (req_length == '0) || (req_length > LEN_W'(MAX_IO_BYTES))
                || (req_sum > DISK_BYTES);
      priority if (liu_ff == '0) begin
         layer_cnt = LIU_W'(1);
      end else if (liu_ff > LIU_W'(MAX_LAYERS)) begin
         layer_cnt = LIU_W'(MAX_LAYERS);
      end else begin
         layer_cnt = liu_ff;
      end
      top_in = LAYER_W'(layer_cnt - LIU_W'(1));
      liu_in = csr_wr_en ? csr_wr_data : liu_ff;
   end

   assign first_blk = off_ff[OFF_W-1:BLK_SHIFT];
   assign final_blk = endm1_ff[OFF_W-1:BLK_SHIFT];
   assign is_first  = (blk_ff == first_blk);
   assign is_final  = (blk_ff == final_blk);

   // block walk counter, also drives the clearing pass after reset
   always_comb begin
      blk_in = blk_ff;
      priority if (cmd.rd_first) begin
         blk_in = first_blk;
      end else if (cmd.clr_step || cmd.rd_next) begin
         blk_in = blk_ff + BLK_W'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
         layer_mask[i] = (LAYER_W'(i) <= top_ff);
      end
      held_bits = ram_rd_data & layer_mask;
      seg_layer = '0;
      seg_found = 1'b0;
      // highest held layer wins
      for (int i = 0; i < MAX_LAYERS; i++) begin
         if (held_bits[i]) begin
            seg_layer = LAYER_W'(i);
            seg_found = 1'b1;
         end
      end
   end

   always_comb begin
      seg_off = is_first ? off_ff : {blk_ff, BLK_SHIFT'(0)};
      priority if (is_first && is_final) begin
         seg_len = len_ff;
      end else if (is_first) begin
         seg_len = LEN_W'(BLOCK_BYTES) - LEN_W'(off_ff[BLK_SHIFT-1:0]);
      end else if (is_final) begin
         seg_len = LEN_W'(endm1_ff[BLK_SHIFT-1:0]) + LEN_W'(1);
      end else begin
         seg_len = LEN_W'(BLOCK_BYTES);
      end
   end

   always_comb begin
      ram_rd_en   = cmd.rd_first || cmd.rd_next;
      ram_rd_addr = cmd.rd_first ? first_blk : blk_ff + BLK_W'(1);
      ram_wr_en   = cmd.clr_step || cmd.wb;
      ram_wr_addr = blk_ff;
      ram_wr_data = cmd.clr_step ? BASE_BITS
                                 : (ram_rd_data | (MAX_LAYERS'(1) << top_ff));
   end

   clbr_ram #(
      .WIDTH (MAX_LAYERS),
      .DEPTH (NUM_BLOCKS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output word register
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_off_in    = out_off_ff;
      out_len_in    = out_len_ff;
      out_layer_in  = out_layer_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         unique case (cmd.emit_sel)
            EMIT_ERR: begin
               out_off_in    = off_ff;
               out_len_in    = len_ff;
               out_layer_in  = '0;
               out_status_in = ST_BAD_RANGE;
               out_last_in   = 1'b1;
            end
            EMIT_WR: begin
               out_off_in    = off_ff;
               out_len_in    = len_ff;
               out_layer_in  = top_ff;
               out_status_in = ST_OK;
               out_last_in   = 1'b1;
            end
            EMIT_SEG: begin
               out_off_in    = seg_off;
               out_len_in    = seg_len;
               out_layer_in  = seg_layer;
               out_status_in = seg_found ? ST_OK : ST_NO_LAYER;
               out_last_in   = is_final;
            end
            default: begin
               out_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         liu_ff       <= LIU_W'(LIU_RESET);
         blk_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         liu_ff       <= liu_in;
         blk_ff       <= blk_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_operation;
         off_ff   <= req_offset;
         len_ff   <= req_length;
         endm1_ff <= OFF_W'(req_sum - (OFF_W + 1)'(1));
         bad_ff   <= req_bad;
         top_ff   <= top_in;
      end
      out_off_ff    <= out_off_in;
      out_len_ff    <= out_len_in;
      out_layer_ff  <= out_layer_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   always_comb begin
      sts.clr_done  = (blk_ff == '1);
      sts.bad_range = bad_ff;
      sts.is_write  = op_ff;
      sts.at_final  = is_final;
      sts.out_free  = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_seg_offset = out_off_ff;
   assign rsp_seg_length = out_len_ff;
   assign rsp_src_layer  = out_layer_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_last       = out_last_ff;

   `CLBR_ASSERT_ALWAYS(a_layer_in_use,
      !(out_valid_ff && out_status_ff == ST_OK) || out_layer_ff <= top_ff,
      "served layer above top layer")

endmodule

// File: design/cow_layer_block_resolver.sv
// a write or range error word is registered out of the start state; a read's first segment
// follows the first bitmap read and comes out of the read state
// reads make one bitmap read per block for n touched blocks (1..17); writes one read-modify-write per block
// throughput is bounded by the single bitmap read port, one block per cycle while the output is not stalled
// reset: synchronous; a clearing pass sets every block to base-only,
// req_ready stays low until it ends
`timescale 1ns / 1ps
module cow_layer_block_resolver
   import clbr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [LIU_W-1:0]    csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [OFF_W-1:0]    req_offset,
   input  logic [LEN_W-1:0]    req_length,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OFF_W-1:0]    rsp_seg_offset,
   output logic [LEN_W-1:0]    rsp_seg_length,
   output logic [LAYER_W-1:0]  rsp_src_layer,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   clbr_cmd_type cmd;
   clbr_sts_type sts;

   clbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   clbr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_operation  (req_operation),
      .req_offset     (req_offset),
      .req_length     (req_length),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_seg_offset (rsp_seg_offset),
      .rsp_seg_length (rsp_seg_length),
      .rsp_src_layer  (rsp_src_layer),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

// File: tb/tb_cow_layer_block_resolver.sv
`timescale 1ns / 1ps
module tb_cow_layer_block_resolver;
   import clbr_pkg::*;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam int HOT_BLKS    = 40;
   localparam int WB_SETTLE   = 40;
   localparam int TAIL_CYCLES = 40;
   localparam int PH_ITEMS    = 57;
   localparam int NUM_PHASES  = 8;
   localparam int PRESSURE_PH = 4;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [OFF_W-1:0]   seg_offset;
      logic [LEN_W-1:0]   seg_length;
      logic [LAYER_W-1:0] src_layer;
      status_type         status;
      logic               last;
   } seg_t;

   typedef struct {
      logic             op;
      logic [OFF_W-1:0] off;
      logic [LEN_W-1:0] len;
      logic             typed;
      seg_t             want;
   } dir_row_t;

   localparam seg_t NO_SEG = '{28'h0, 17'h0, 3'd0, ST_OK, 1'b0};
   localparam int N_DIR = 20;

   // layer bits at reset: 2 layers in use, so writes land in layer 1
   dir_row_t dir_rows [N_DIR] = '{
      '{OP_READ,  28'h0000000, 17'd4096,   1'b1, '{28'h0000000, 17'd4096,   3'd0, ST_OK, 1'b1}},
      '{OP_READ,  28'hFFFF000, 17'd4096,   1'b1, '{28'hFFFF000, 17'd4096,   3'd0, ST_OK, 1'b1}},
      '{OP_READ,  28'h0000064, 17'd0,      1'b1,
        '{28'h0000064, 17'd0,      3'd0, ST_BAD_RANGE, 1'b1}},
      '{OP_READ,  28'h0000000, 17'd65537,  1'b1,
        '{28'h0000000, 17'd65537,  3'd0, ST_BAD_RANGE, 1'b1}},
      '{OP_WRITE, 28'hFFFFFFF, 17'h1FFFF,  1'b1,
        '{28'hFFFFFFF, 17'h1FFFF,  3'd0, ST_BAD_RANGE, 1'b1}},
      '{OP_WRITE, 28'hFFFFFFF, 17'd1,      1'b1, '{28'hFFFFFFF, 17'd1,      3'd1, ST_OK, 1'b1}},
      '{OP_READ,  28'hFFFFFFF, 17'd2,      1'b1,
        '{28'hFFFFFFF, 17'd2,      3'd0, ST_BAD_RANGE, 1'b1}},
      '{OP_WRITE, 28'hFFF0001, 17'd65536,  1'b1,
        '{28'hFFF0001, 17'd65536,  3'd0, ST_BAD_RANGE, 1'b1}},
      '{OP_READ,  28'hFFFF800, 17'd2048,   1'b0, NO_SEG},
      '{OP_READ,  28'h0000064, 17'd65536,  1'b0, NO_SEG},
      '{OP_WRITE, 28'h0002000, 17'd65536,  1'b1, '{28'h0002000, 17'd65536,  3'd1, ST_OK, 1'b1}},
      '{OP_READ,  28'h0000FA0, 17'd65536,  1'b0, NO_SEG},
      '{OP_WRITE, 28'h0000000, 17'd1,      1'b1, '{28'h0000000, 17'd1,      3'd1, ST_OK, 1'b1}},
      '{OP_READ,  28'h0000000, 17'd12288,  1'b0, NO_SEG},
      '{OP_READ,  28'hFFF0000, 17'd65536,  1'b0, NO_SEG},
      '{OP_WRITE, 28'hFFF0000, 17'd65536,  1'b1, '{28'hFFF0000, 17'd65536,  3'd1, ST_OK, 1'b1}},
      '{OP_READ,  28'hAAAAAAA, 17'h05555,  1'b0, NO_SEG},
      '{OP_READ,  28'h5555555, 17'h0AAAA,  1'b0, NO_SEG},
      '{OP_READ,  28'hFFF0000, 17'd65536,  1'b0, NO_SEG},
      '{OP_WRITE, 28'h0000000, 17'd0,      1'b1,
        '{28'h0000000, 17'd0,      3'd0, ST_BAD_RANGE, 1'b1}}
   };

   // -1 picks a random register value
   int ph_layers [NUM_PHASES] = '{8, 0, 15, 1, 5, 3, -1, 8};
   int ph_snd    [NUM_PHASES] = '{0, 71, 0, 14, 71, 0, 14, 0};
   int ph_rcv    [NUM_PHASES] = '{0, 0, 71, 14, 0, 71, 14, 0};

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [LIU_W-1:0]    csr_wr_data;
   logic                req_valid;
   logic                req_ready;
   logic                req_operation;
   logic [OFF_W-1:0]    req_offset;
   logic [LEN_W-1:0]    req_length;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [OFF_W-1:0]    rsp_seg_offset;
   logic [LEN_W-1:0]    rsp_seg_length;
   logic [LAYER_W-1:0]  rsp_src_layer;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;

   logic [MAX_LAYERS-1:0] blk_bits [NUM_BLOCKS];
   logic [LIU_W-1:0]      cur_layers;
   seg_t                  resolved [$];
   seg_t                  seg_queue [$];
   int                    mismatches;
   int                    cycle_count;
   int                    snd_idle_pct;
   int                    rcv_stall_pct;

   cow_layer_block_resolver u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_offset     (req_offset),
      .req_length     (req_length),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_seg_offset (rsp_seg_offset),
      .rsp_seg_length (rsp_seg_length),
      .rsp_src_layer  (rsp_src_layer),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cow_layer_block_resolver: mismatch");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (!reset)
         rsp_ready = ($urandom_range(99) >= rcv_stall_pct);
   end

   function automatic int top_layer();
      int n;
      n = cur_layers;
      if (n < 1)
         n = 1;
      if (n > MAX_LAYERS)
         n = MAX_LAYERS;
      return n - 1;
   endfunction

   // fills resolved with the words one request yields and updates the layer bits
   function automatic void resolve(input logic op, input logic [OFF_W-1:0] off,
                                   input logic [LEN_W-1:0] len);
      longint end_byte, bstart, s, e;
      int     first_blk, last_blk, top, lyr;
      seg_t   seg;
      resolved.delete();
      end_byte = longint'(off) + longint'(len);
      if (len == 0 || len > MAX_IO_BYTES || end_byte > longint'(DISK_BYTES)) begin
         resolved.push_back('{off, len, LAYER_W'(0), ST_BAD_RANGE, 1'b1});
         return;
      end
      top       = top_layer();
      first_blk = int'(off >> BLK_SHIFT);
      last_blk  = int'((end_byte - 1) >> BLK_SHIFT);
      if (op == OP_WRITE) begin
         resolved.push_back('{off, len, LAYER_W'(top), ST_OK, 1'b1});
         for (int b = first_blk; b <= last_blk; b++)
            blk_bits[b][top] = 1'b1;
         return;
      end
      for (int b = first_blk; b <= last_blk; b++) begin
         bstart = longint'(b) << BLK_SHIFT;
         s = (longint'(off) > bstart) ? longint'(off) : bstart;
         e = (end_byte < bstart + BLOCK_BYTES) ? end_byte : bstart + BLOCK_BYTES;
         // topmost layer in use that holds the block
         lyr = top;
         while (lyr >= 0 && !blk_bits[b][lyr])
            lyr--;
         seg.seg_offset = OFF_W'(s);
         seg.seg_length = LEN_W'(e - s);
         seg.src_layer  = (lyr >= 0) ? LAYER_W'(lyr) : LAYER_W'(0);
         seg.status     = (lyr >= 0) ? ST_OK : ST_NO_LAYER;
         seg.last       = (b == last_blk);
         resolved.push_back(seg);
      end
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      seg_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (seg_queue.size() == 0) begin
            mismatches++;
            $display("%0t ns: expected no word, actual off %0h len %0h layer %0d st %0d last %0b",
                     $time, rsp_seg_offset, rsp_seg_length, rsp_src_layer, rsp_status,
                     rsp_last);
         end else begin
            want = seg_queue.pop_front();
            check_field("seg_offset", want.seg_offset, rsp_seg_offset);
            check_field("seg_length", want.seg_length, rsp_seg_length);
            check_field("src_layer", want.src_layer, rsp_src_layer);
            check_field("status", longint'(want.status), rsp_status);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // returns at the edge that takes the request; valid stays up until the next falling edge
   task automatic send_req(input logic op, input logic [OFF_W-1:0] off,
                           input logic [LEN_W-1:0] len, input logic typed, input seg_t want);
      @(negedge clock);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_operation = op;
      req_offset    = off;
      req_length    = len;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      resolve(op, off, len);
      if (typed)
         seg_queue.push_back(want);
      else
         foreach (resolved[i])
            seg_queue.push_back(resolved[i]);
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (seg_queue.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_layers(input logic [LIU_W-1:0] v);
      quiesce();
      // a write may still be updating the bitmap after its word went out
      repeat (WB_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en  = 1'b0;
      cur_layers = v;
   endtask

   task automatic pick_request(output logic op, output logic [OFF_W-1:0] off,
                               output logic [LEN_W-1:0] len);
      int kind, blk;
      longint gap;
      kind = $urandom_range(99);
      op   = ($urandom_range(99) < 35) ? OP_WRITE : OP_READ;
      if (kind < 80) begin
         // small windows at both disk ends so reads land on written blocks
         blk = (($urandom_range(3) == 0) ? NUM_BLOCKS - HOT_BLKS : 0) +
               $urandom_range(HOT_BLKS - 1);
         off = OFF_W'(blk) << BLK_SHIFT;
         if ($urandom_range(3) != 0)
            off = off + OFF_W'($urandom_range(BLOCK_BYTES - 1));
         case ($urandom_range(3))
            0: len = LEN_W'($urandom_range(1, MAX_IO_BYTES));
            1: len = LEN_W'($urandom_range(1, 2 * BLOCK_BYTES));
            2: len = LEN_W'($urandom_range(1, 16) * BLOCK_BYTES);
            default: len = LEN_W'($urandom_range(1, 64));
         endcase
      end else if (kind < 90) begin
         off = OFF_W'($urandom());
         len = LEN_W'($urandom_range(1, MAX_IO_BYTES));
      end else begin
         off = OFF_W'($urandom());
         case ($urandom_range(2))
            0: len = '0;
            1: len = LEN_W'($urandom_range(MAX_IO_BYTES + 1, (1 << LEN_W) - 1));
            default: begin
               // runs past the disk end
               off = OFF_W'(longint'(DISK_BYTES) - $urandom_range(1, BLOCK_BYTES));
               gap = longint'(DISK_BYTES) - longint'(off);
               len = LEN_W'($urandom_range(int'(gap) + 1, MAX_IO_BYTES));
            end
         endcase
      end
   endtask

   initial begin
      logic             op;
      logic [OFF_W-1:0] off;
      logic [LEN_W-1:0] len;
      int               lv;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_valid     = 1'b0;
      req_operation = OP_READ;
      req_offset    = '0;
      req_length    = '0;
      rsp_ready     = 1'b0;
      mismatches    = 0;
      cycle_count   = 0;
      snd_idle_pct  = 0;
      rcv_stall_pct = 0;
      cur_layers    = LIU_W'(LIU_RESET);
      for (int b = 0; b < NUM_BLOCKS; b++)
         blk_bits[b] = BASE_BITS;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < N_DIR; r++)
         send_req(dir_rows[r].op, dir_rows[r].off, dir_rows[r].len, dir_rows[r].typed,
                  dir_rows[r].want);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         lv = (ph_layers[ph] < 0) ? $urandom_range(15) : ph_layers[ph];
         set_layers(LIU_W'(lv));
         snd_idle_pct  = ph_snd[ph];
         rcv_stall_pct = ph_rcv[ph];
         for (int n = 0; n < PH_ITEMS; n++) begin
            pick_request(op, off, len);
            send_req(op, off, len, 1'b0, NO_SEG);
            if (ph == PRESSURE_PH && n % 16 == 15)
               quiesce();
         end
      end

      quiesce();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("cow_layer_block_resolver: match");
      else
         $display("cow_layer_block_resolver: mismatch");
      $finish;
   end

endmodule
